>>> src/uart_rbf_pkg.sv
// uart_rbf_pkg: shared types, register offsets, codes and fifo sizing
// for the uart register block; no dependencies
package uart_rbf_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
    localparam int CMP_W      = (FILL_W > 3) ? FILL_W : 3;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(FIFO_DEPTH);

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ALIGN    = 2'd1;
    localparam logic [1:0] STATUS_UNMAPPED = 2'd2;

    localparam logic [3:0] ACCESS_WORD = 4'd4;

    localparam logic [11:0] OFF_TXDATA = 12'h000;
    localparam logic [11:0] OFF_RXDATA = 12'h004;
    localparam logic [11:0] OFF_TXCTRL = 12'h008;
    localparam logic [11:0] OFF_RXCTRL = 12'h00C;
    localparam logic [11:0] OFF_IE     = 12'h010;
    localparam logic [11:0] OFF_IP     = 12'h014;
    localparam logic [11:0] OFF_DIV    = 12'h018;
    localparam logic [11:0] OFF_RSVD   = 12'h01C;

    localparam logic [18:0] TXCTRL_MASK = 19'h70003;
    localparam logic [18:0] RXCTRL_MASK = 19'h70001;
    localparam logic [15:0] DIV_RESET   = 16'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] offset;
        logic [3:0]  access_bytes;
        logic [31:0] write_data;
        logic        rx_offered;
        logic [7:0]  rx_byte;
    } uart_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  bus_status;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
    } uart_rsp_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] head,
                                                 input logic [FILL_W-1:0] fill);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(fill);
        if (s >= SUM_DEPTH)
        begin
            s = s - SUM_DEPTH;
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

>>> src/uart_register_block_with_fifos_unit.sv
// uart_register_block_with_fifos_unit: register block with tx and rx fifos
// depends on uart_rbf_pkg
//
// usage:
//   req channel carries one item per cycle while req_stall is low: a 32-bit bus read, a bus write
//   or one baud tick. rsp channel returns exactly one item per req item,
//   in order: read data, bus status, the byte sent on a tick and irq.
//   an item is registered in the middle stage, then in the rsp register; throughput
//   is one item per cycle while rsp is not stalled, limited by the single read-modify-write
//   pass over the fifo pointers and the registered read of each fifo memory.
//   fifo bytes live in two synchronous memories; pointers, fill counts,
//   control registers and the baud counter sit in flops and are updated in
//   the cycle an item is accepted, so the next item sees them at once.
//   a pop reads the memory at acceptance and the byte joins the rsp item in
//   the following stage.
//   reset clears pointers, fills, control, ie, ip and the tick counter and
//   sets div to 3; fifo contents are not cleared and no clearing pass runs.
//   when rsp is stalled the rsp register holds and one more req item is
//   taken into the middle stage; req_stall rises only when both are full.
module uart_register_block_with_fifos_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  uart_rbf_pkg::uart_req_t req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output uart_rbf_pkg::uart_rsp_t rsp
);
    import uart_rbf_pkg::*;

    logic [7:0] tx_mem [FIFO_DEPTH];
    logic [7:0] rx_mem [FIFO_DEPTH];

    logic [PTR_W-1:0]  tx_head_reg, tx_head_next;
    logic [FILL_W-1:0] tx_fill_reg, tx_fill_next;
    logic [PTR_W-1:0]  rx_head_reg, rx_head_next;
    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [18:0]       tx_control_reg, tx_control_next;
    logic [18:0]       rx_control_reg, rx_control_next;
    logic [1:0]        irq_enable_reg, irq_enable_next;
    logic [1:0]        irq_pending_reg, irq_pending_next;
    logic [15:0]       baud_divisor_reg, baud_divisor_next;
    logic [15:0]       tick_count_reg, tick_count_next;

    logic [7:0]        tx_rdata_reg;
    logic [7:0]        rx_rdata_reg;

    logic              s1_valid_reg;
    logic [31:0]       s1_rd_base_reg;
    logic [1:0]        s1_status_reg;
    logic              s1_tx_pop_reg;
    logic              s1_rx_pop_reg;
    logic              s1_irq_reg;

    logic              rsp_valid_reg;
    uart_rsp_t         rsp_reg;
    uart_rsp_t         s1_rsp;

    logic              accept;
    logic              s1_move;
    logic              is_write;
    logic              tx_push, tx_pop, rx_push, rx_pop;
    logic              fire;
    logic [15:0]       count_inc;
    logic [31:0]       rd_base;
    logic [1:0]        status;
    logic [PTR_W-1:0]  tx_wr_addr, rx_wr_addr;

    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign is_write  = (req.mode == MODE_WRITE);

    assign tx_wr_addr = ptr_add(tx_head_reg, tx_fill_reg);
    assign rx_wr_addr = ptr_add(rx_head_reg, rx_fill_reg);

    always_comb
    begin
        tx_control_next   = tx_control_reg;
        rx_control_next   = rx_control_reg;
        irq_enable_next   = irq_enable_reg;
        irq_pending_next  = irq_pending_reg;
        baud_divisor_next = baud_divisor_reg;
        tick_count_next   = tick_count_reg;
        tx_push           = 1'b0;
        tx_pop            = 1'b0;
        rx_push           = 1'b0;
        rx_pop            = 1'b0;
        rd_base           = '0;
        status            = STATUS_OK;
        count_inc         = tick_count_reg + 16'd1;
        fire              = 1'b0;

        if (req.mode == MODE_READ || req.mode == MODE_WRITE)
        begin
            if (req.access_bytes != ACCESS_WORD)
            begin
                status = STATUS_ALIGN;
            end
            else
            begin
                case (req.offset)
                    OFF_TXDATA:
                    begin
                        if (is_write)
                            tx_push = (tx_fill_reg != FILL_FULL);
                        else
                            rd_base = {(tx_fill_reg == FILL_FULL), 31'd0};
                    end
                    OFF_RXDATA:
                    begin
                        if (!is_write)
                        begin
                            rx_pop  = (rx_fill_reg != '0);
                            rd_base = {(rx_fill_reg == '0), 31'd0};
                        end
                    end
                    OFF_TXCTRL:
                    begin
                        if (is_write)
                            tx_control_next = req.write_data[18:0] & TXCTRL_MASK;
                        else
                            rd_base = {13'd0, tx_control_reg};
                    end
                    OFF_RXCTRL:
                    begin
                        if (is_write)
                            rx_control_next = req.write_data[18:0] & RXCTRL_MASK;
                        else
                            rd_base = {13'd0, rx_control_reg};
                    end
                    OFF_IE:
                    begin
                        if (is_write)
                            irq_enable_next = req.write_data[1:0];
                        else
                            rd_base = {30'd0, irq_enable_reg};
                    end
                    OFF_IP:
                    begin
                        if (!is_write)
                            rd_base = {30'd0, irq_pending_reg};
                    end
                    OFF_DIV:
                    begin
                        if (is_write)
                            baud_divisor_next = req.write_data[15:0];
                        else
                            rd_base = {16'd0, baud_divisor_reg};
                    end
                    OFF_RSVD:
                    begin
                        rd_base = '0;
                    end
                    default:
                    begin
                        status = STATUS_UNMAPPED;
                    end
                endcase
            end
        end
        else if (req.mode == MODE_TICK)
        begin
            fire            = (count_inc >= baud_divisor_reg);
            tx_pop          = fire && tx_control_reg[0] && (tx_fill_reg != '0);
            rx_push         = fire && rx_control_reg[0] && (rx_fill_reg != FILL_FULL)
                              && req.rx_offered;
            tick_count_next = fire ? 16'd0 : count_inc;
        end

        tx_head_next = tx_pop ? ptr_inc(tx_head_reg) : tx_head_reg;
        rx_head_next = rx_pop ? ptr_inc(rx_head_reg) : rx_head_reg;
        tx_fill_next = tx_fill_reg + FILL_W'(tx_push) - FILL_W'(tx_pop);
        rx_fill_next = rx_fill_reg + FILL_W'(rx_push) - FILL_W'(rx_pop);

        if (req.mode == MODE_TICK)
        begin
            irq_pending_next[0] = (CMP_W'(tx_control_reg[18:16]) > CMP_W'(tx_fill_next))
                                  && irq_enable_reg[0];
            irq_pending_next[1] = (CMP_W'(rx_control_reg[18:16]) < CMP_W'(rx_fill_next))
                                  && irq_enable_reg[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg      <= '0;
            tx_fill_reg      <= '0;
            rx_head_reg      <= '0;
            rx_fill_reg      <= '0;
            tx_control_reg   <= '0;
            rx_control_reg   <= '0;
            irq_enable_reg   <= '0;
            irq_pending_reg  <= '0;
            baud_divisor_reg <= DIV_RESET;
            tick_count_reg   <= '0;
        end
        else if (accept)
        begin
            tx_head_reg      <= tx_head_next;
            tx_fill_reg      <= tx_fill_next;
            rx_head_reg      <= rx_head_next;
            rx_fill_reg      <= rx_fill_next;
            tx_control_reg   <= tx_control_next;
            rx_control_reg   <= rx_control_next;
            irq_enable_reg   <= irq_enable_next;
            irq_pending_reg  <= irq_pending_next;
            baud_divisor_reg <= baud_divisor_next;
            tick_count_reg   <= tick_count_next;
        end
    end

    // fifo memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (accept && tx_push)
            tx_mem[tx_wr_addr] <= req.write_data[7:0];
        if (accept && tx_pop)
            tx_rdata_reg <= tx_mem[tx_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && rx_push)
            rx_mem[rx_wr_addr] <= req.rx_byte;
        if (accept && rx_pop)
            rx_rdata_reg <= rx_mem[rx_head_reg];
    end

    // middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_base_reg <= rd_base;
            s1_status_reg  <= status;
            s1_tx_pop_reg  <= tx_pop;
            s1_rx_pop_reg  <= rx_pop;
            s1_irq_reg     <= (irq_pending_next != 2'd0);
        end
    end

    always_comb
    begin
        s1_rsp.read_data  = s1_rd_base_reg | (s1_rx_pop_reg ? {24'd0, rx_rdata_reg} : 32'd0);
        s1_rsp.bus_status = s1_status_reg;
        s1_rsp.tx_valid   = s1_tx_pop_reg;
        s1_rsp.tx_byte    = s1_tx_pop_reg ? tx_rdata_reg : 8'd0;
        s1_rsp.irq        = s1_irq_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (s1_move)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            rsp_reg <= s1_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/uart_rbf_checker.sv
// uart_rbf_checker: port-level assertions for the uart register block
// depends on uart_rbf_pkg; bound to uart_register_block_with_fifos_unit
module uart_rbf_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_stall,
    input logic                    rsp_valid,
    input logic                    rsp_stall,
    input uart_rbf_pkg::uart_rsp_t rsp
);
    import uart_rbf_pkg::*;

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp item changed while stalled");

    // no rsp item appears from an idle input with nothing in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid && !(req_valid && !req_stall) && $past(!(req_valid && !req_stall))
        |=> !rsp_valid)
    else $error("rsp item without an accepted req item");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.tx_valid |-> rsp.tx_byte == 8'd0)
    else $error("tx byte set without tx valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.bus_status != STATUS_OK
        |-> rsp.read_data == 32'd0 && !rsp.tx_valid)
    else $error("failed access carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.bus_status == STATUS_OK || rsp.bus_status == STATUS_ALIGN
                      || rsp.bus_status == STATUS_UNMAPPED)
    else $error("bad bus status");

endmodule

bind uart_register_block_with_fifos_unit uart_rbf_checker u_uart_rbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> dv/testbench.sv
// testbench for uart_register_block_with_fifos_unit: directed and random bus reads,
// writes and ticks, checked item by item against a predictor of the register block
// depends on uart_rbf_pkg and the unit's rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_rbf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 37;
    localparam logic [1:0]  MODE_NONE = 2'd3;
    localparam logic [11:0] REG_OFFS[8] = '{OFF_TXDATA, OFF_RXDATA, OFF_TXCTRL, OFF_RXCTRL,
                                           OFF_IE, OFF_IP, OFF_DIV, OFF_RSVD};

    logic      clk;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    uart_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    uart_rsp_t rsp;

    logic       idle_on = 1'b1;
    int         fail_count = 0;
    uart_rsp_t  rsp_due_q[$];

    logic [7:0]  tx_bytes[$];
    logic [7:0]  rx_bytes[$];
    logic [18:0] txctrl_r = '0;
    logic [18:0] rxctrl_r = '0;
    logic [1:0]  ie_r = '0;
    logic [1:0]  ip_r = '0;
    logic [15:0] div_r = DIV_RESET;
    logic [15:0] tick_r = '0;

    uart_register_block_with_fifos_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic uart_rsp_t uart_predict(input uart_req_t it);
        uart_rsp_t r;
        logic      wr;
        r = '0;
        wr = (it.mode == MODE_WRITE);
        if (it.mode == MODE_READ || it.mode == MODE_WRITE)
        begin
            if (it.access_bytes != ACCESS_WORD)
            begin
                r.bus_status = STATUS_ALIGN;
            end
            else
            begin
                case (it.offset)
                    OFF_TXDATA:
                        if (wr)
                        begin
                            if (tx_bytes.size() < FIFO_DEPTH)
                            begin
                                tx_bytes.push_back(it.write_data[7:0]);
                            end
                        end
                        else
                        begin
                            r.read_data[31] = (tx_bytes.size() >= FIFO_DEPTH);
                        end
                    OFF_RXDATA:
                        if (!wr)
                        begin
                            if (rx_bytes.size() == 0)
                            begin
                                r.read_data = 32'h8000_0000;
                            end
                            else
                            begin
                                r.read_data = {24'b0, rx_bytes.pop_front()};
                            end
                        end
                    OFF_TXCTRL:
                        if (wr) txctrl_r = it.write_data[18:0] & TXCTRL_MASK;
                        else r.read_data = 32'(txctrl_r);
                    OFF_RXCTRL:
                        if (wr) rxctrl_r = it.write_data[18:0] & RXCTRL_MASK;
                        else r.read_data = 32'(rxctrl_r);
                    OFF_IE:
                        if (wr) ie_r = it.write_data[1:0];
                        else r.read_data = 32'(ie_r);
                    OFF_IP:
                        if (!wr) r.read_data = 32'(ip_r);
                    OFF_DIV:
                        if (wr) div_r = it.write_data[15:0];
                        else r.read_data = 32'(div_r);
                    OFF_RSVD:
                        ;
                    default:
                        r.bus_status = STATUS_UNMAPPED;
                endcase
            end
        end
        else if (it.mode == MODE_TICK)
        begin
            tick_r = tick_r + 16'd1;
            if (tick_r >= div_r)
            begin
                if (txctrl_r[0] && tx_bytes.size() != 0)
                begin
                    r.tx_byte = tx_bytes.pop_front();
                    r.tx_valid = 1'b1;
                end
                if (rxctrl_r[0] && rx_bytes.size() < FIFO_DEPTH && it.rx_offered)
                begin
                    rx_bytes.push_back(it.rx_byte);
                end
                tick_r = '0;
            end
            ip_r[0] = (int'(txctrl_r[18:16]) > tx_bytes.size()) && ie_r[0];
            ip_r[1] = (int'(rxctrl_r[18:16]) < rx_bytes.size()) && ie_r[1];
        end
        r.irq = |ip_r;
        return r;
    endfunction

    function automatic uart_req_t make_req(input logic [1:0] mode, input logic [11:0] offset,
                                           input logic [3:0] bytes, input logic [31:0] wd,
                                           input logic offered, input logic [7:0] rxb);
        uart_req_t it;
        it.mode = mode;
        it.offset = offset;
        it.access_bytes = bytes;
        it.write_data = wd;
        it.rx_offered = offered;
        it.rx_byte = rxb;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input uart_req_t it);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        rsp_due_q.push_back(uart_predict(it));
        @(negedge clk);
    endtask

    task automatic reg_read(input logic [11:0] offset);
        send_item(make_req(MODE_READ, offset, ACCESS_WORD, $urandom, 1'($urandom),
                           8'($urandom)));
    endtask

    task automatic reg_write(input logic [11:0] offset, input logic [31:0] wd);
        send_item(make_req(MODE_WRITE, offset, ACCESS_WORD, wd, 1'($urandom), 8'($urandom)));
    endtask

    task automatic tick(input logic offered, input logic [7:0] rxb);
        send_item(make_req(MODE_TICK, 12'($urandom), 4'($urandom), $urandom, offered, rxb));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        uart_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = rsp_due_q.pop_front();
                check_field("read_data", want.read_data, rsp.read_data);
                check_field("bus_status", 32'(want.bus_status), 32'(rsp.bus_status));
                check_field("tx_valid", 32'(want.tx_valid), 32'(rsp.tx_valid));
                check_field("tx_byte", 32'(want.tx_byte), 32'(rsp.tx_byte));
                check_field("irq", 32'(want.irq), 32'(rsp.irq));
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        int quiet;
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[uart_register_block_with_fifos_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic test_reset_values();
        reg_read(OFF_DIV);
        reg_read(OFF_RXDATA);
    endtask

    task automatic test_bus_errors();
        send_item(make_req(MODE_READ, OFF_TXCTRL, 4'd0, '0, 1'b0, '0));
        send_item(make_req(MODE_WRITE, OFF_DIV, 4'hF, '1, 1'b1, '1));
        reg_read(12'hFFF);
        reg_write(OFF_RSVD, '1);
        send_item(make_req(MODE_NONE, '1, '1, '1, 1'b1, '1));
    endtask

    task automatic test_fifos_and_irq();
        reg_write(OFF_TXCTRL, '1);
        reg_write(OFF_RXCTRL, '1);
        reg_write(OFF_IE, '1);
        reg_read(OFF_IP);
        for (int i = 0; i < FIFO_DEPTH + 1; i++)
        begin
            reg_write(OFF_TXDATA, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
        end
        reg_read(OFF_TXDATA);
        tick(1'b1, 8'hFF);
        reg_write(OFF_DIV, '0);
        tick(1'b1, 8'h00);
        tick(1'b0, 8'hA5);
        reg_read(OFF_RXDATA);
        reg_read(OFF_IP);
    endtask

    task automatic run_traffic(input int count);
        int         done;
        int         n;
        int         pick;
        logic [11:0] offset;
        logic [31:0] wd;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            n = $urandom_range(1, 10);
            if (pick < 12)
            begin
                offset = REG_OFFS[$urandom_range(2, 6)];
                wd = $urandom;
                if (offset == OFF_DIV && $urandom_range(19) != 0)
                begin
                    wd[15:0] = 16'($urandom_range(0, 4));
                end
                if ((offset == OFF_TXCTRL || offset == OFF_RXCTRL) && $urandom_range(4) != 0)
                begin
                    wd[0] = 1'b1;
                end
                reg_write(offset, wd);
                done++;
            end
            else if (pick < 35)
            begin
                repeat (n) reg_write(OFF_TXDATA, $urandom);
                done += n;
            end
            else if (pick < 65)
            begin
                repeat (n + 2) tick($urandom_range(9) != 0, 8'($urandom));
                done += n + 2;
            end
            else if (pick < 80)
            begin
                repeat (n) reg_read(OFF_RXDATA);
                done += n;
            end
            else if (pick < 90)
            begin
                reg_read(REG_OFFS[$urandom_range(7)]);
                done++;
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    offset = $urandom_range(1) ? 12'($urandom) : REG_OFFS[$urandom_range(7)];
                    send_item(make_req(2'($urandom), offset, 4'($urandom), $urandom,
                                       1'($urandom), 8'($urandom)));
                end
                done += n;
            end
        end
    endtask

    task automatic test_random_idle();
        idle_on = 1'b1;
        run_traffic(1300);
    endtask

    task automatic test_random_back_to_back();
        idle_on = 1'b0;
        run_traffic(300);
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_bus_errors();
        test_fifos_and_irq();
        test_random_idle();
        test_random_back_to_back();
        req_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[uart_register_block_with_fifos_unit] OK");
        end
        else
        begin
            $display("[uart_register_block_with_fifos_unit] ERROR");
        end
        $finish;
    end

endmodule
